### rtl/core/sha1sh_pkg.sv
// ----------------------------------------------------------------------------
// sha1sh_pkg
// Shared types, constants and helpers for the SHA-1 stream hasher.
// ----------------------------------------------------------------------------
package sha1sh_pkg;

  localparam int unsigned WordW     = 32;
  localparam int unsigned BlkWords  = 16;
  localparam int unsigned BlkBytes  = 64;
  localparam int unsigned DigWords  = 5;
  localparam int unsigned NumRounds = 80;
  localparam int unsigned LenW      = 61;
  localparam int unsigned FillW     = 6;
  localparam int unsigned RoundW    = 7;
  localparam int unsigned IdxW      = 3;

  // Block queue between front and engine
  localparam int unsigned QDepth = 2;
  localparam int unsigned QPtrW  = $clog2(QDepth);
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  // Byte position where the 64-bit length field starts
  localparam logic [FillW-1:0] LenPos  = 6'd56;
  localparam logic [7:0]       PadByte = 8'h80;

  localparam logic [WordW-1:0] K0 = 32'h5A827999;
  localparam logic [WordW-1:0] K1 = 32'h6ED9EBA1;
  localparam logic [WordW-1:0] K2 = 32'h8F1BBCDC;
  localparam logic [WordW-1:0] K3 = 32'hCA62C1D6;

  // Initial chaining value, index 0 is h0
  localparam logic [DigWords-1:0][WordW-1:0] InitChain = {
    32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE, 32'hEFCDAB89, 32'h67452301
  };

  localparam logic [RoundW-1:0] LastRound = 7'(NumRounds - 1);
  localparam logic [IdxW-1:0]   LastIdx   = 3'(DigWords - 1);

  typedef logic [BlkWords-1:0][WordW-1:0] blk_words_t;
  typedef logic [DigWords-1:0][WordW-1:0] dig_words_t;

  // One 512-bit block plus a flag for the final block of a message
  typedef struct packed {
    blk_words_t words;
    logic       last;
  } blk_t;

  // Finished digest handed from the engine to the output stage
  typedef struct packed {
    logic       valid;
    dig_words_t words;
  } dig_t;

  function automatic logic [WordW-1:0] rotl1(input logic [WordW-1:0] x);
    return {x[WordW-2:0], x[WordW-1]};
  endfunction

  function automatic logic [WordW-1:0] rotl5(input logic [WordW-1:0] x);
    return {x[WordW-6:0], x[WordW-1:WordW-5]};
  endfunction

  function automatic logic [WordW-1:0] rotl30(input logic [WordW-1:0] x);
    return {x[1:0], x[WordW-1:2]};
  endfunction

  // Round function plus round constant
  function automatic logic [WordW-1:0] round_fk(input logic [RoundW-1:0] r,
                                                input logic [WordW-1:0] b,
                                                input logic [WordW-1:0] c,
                                                input logic [WordW-1:0] d);
    logic [WordW-1:0] res;
    priority if (r < 7'd20) begin
      res = ((b & c) | (~b & d)) + K0;
    end else if (r < 7'd40) begin
      res = (b ^ c ^ d) + K1;
    end else if (r < 7'd60) begin
      res = ((b & c) | (b & d) | (c & d)) + K2;
    end else begin
      res = (b ^ c ^ d) + K3;
    end
    return res;
  endfunction

endpackage

### rtl/core/sha1sh_front.sv
// ----------------------------------------------------------------------------
// sha1sh_front
// Packs incoming bytes into a block buffer and emits data and padding blocks.
// ----------------------------------------------------------------------------
module sha1sh_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [7:0]        data_byte_i,
  input  logic              has_byte_i,
  input  logic              end_of_message_i,
  input  logic              push,
  output logic              full,
  output sha1sh_pkg::blk_t  blk_o,
  output logic              blk_push_o,
  input  logic              blk_full_i
);
  import sha1sh_pkg::*;

  typedef enum logic [3:0] {
    F_RUN   = 4'b0001,
    F_FLUSH = 4'b0010,
    F_PAD1  = 4'b0100,
    F_PAD2  = 4'b1000
  } front_state_e;

  front_state_e     state_q, state_d;
  logic [FillW-1:0] fill_q, fill_d;
  logic [LenW-1:0]  len_q, len_d;
  logic             eom_pend_q, eom_pend_d;
  blk_words_t       buf_q;
  blk_words_t       pad_words;
  logic [63:0]      bit_len;
  logic             accept;
  logic             short_pad;

  assign full      = (state_q != F_RUN);
  assign accept    = push && !full;
  assign bit_len   = {len_q, 3'b000};
  assign short_pad = (fill_q < LenPos);

  // Padded block: first pad block keeps data below fill, then 0x80;
  // length goes in when it fits (or always in the second pad block).
  always_comb begin
    logic [7:0]       b;
    logic [FillW-1:0] p;
    pad_words = '0;
    for (int w = 0; w < BlkWords; w++) begin
      for (int l = 0; l < 4; l++) begin
        p = FillW'(4 * w + l);
        if (state_q == F_PAD2) begin
          b = 8'h00;
        end else if (p < fill_q) begin
          b = buf_q[w][8*(3-l) +: 8];
        end else if (p == fill_q) begin
          b = PadByte;
        end else begin
          b = 8'h00;
        end
        if ((state_q == F_PAD2 || short_pad) && p >= LenPos) begin
          b = bit_len[8*(63-(4*w+l)) +: 8];
        end
        pad_words[w][8*(3-l) +: 8] = b;
      end
    end
  end

  always_comb begin
    blk_push_o = (state_q != F_RUN) && !blk_full_i;
    if (state_q == F_FLUSH) begin
      blk_o.words = buf_q;
      blk_o.last  = 1'b0;
    end else begin
      blk_o.words = pad_words;
      blk_o.last  = (state_q == F_PAD2) || short_pad;
    end
  end

  always_comb begin
    state_d    = state_q;
    fill_d     = fill_q;
    len_d      = len_q;
    eom_pend_d = eom_pend_q;
    unique case (state_q)
      F_RUN: begin
        if (accept) begin
          if (has_byte_i) begin
            fill_d = fill_q + 1'b1;
            len_d  = len_q + 1'b1;
            if (fill_q == FillW'(BlkBytes - 1)) begin
              state_d    = F_FLUSH;
              eom_pend_d = end_of_message_i;
            end else if (end_of_message_i) begin
              state_d = F_PAD1;
            end
          end else if (end_of_message_i) begin
            state_d = F_PAD1;
          end
        end
      end
      F_FLUSH: begin
        if (blk_push_o) begin
          state_d = eom_pend_q ? F_PAD1 : F_RUN;
        end
      end
      F_PAD1: begin
        if (blk_push_o) begin
          if (short_pad) begin
            state_d = F_RUN;
            fill_d  = '0;
            len_d   = '0;
          end else begin
            state_d = F_PAD2;
          end
        end
      end
      F_PAD2: begin
        if (blk_push_o) begin
          state_d = F_RUN;
          fill_d  = '0;
          len_d   = '0;
        end
      end
      default: state_d = F_RUN;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= F_RUN;
      fill_q     <= '0;
      len_q      <= '0;
      eom_pend_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      fill_q     <= fill_d;
      len_q      <= len_d;
      eom_pend_q <= eom_pend_d;
    end
  end

  // Byte lane write, big-endian within each word
  always_ff @(posedge clk_i) begin
    if (accept && has_byte_i) begin
      buf_q[fill_q[5:2]][{~fill_q[1:0], 3'b000} +: 8] <= data_byte_i;
    end
  end

endmodule

### rtl/core/sha1sh_blkq.sv
// ----------------------------------------------------------------------------
// sha1sh_blkq
// Short block queue that decouples the front from the compression engine.
// ----------------------------------------------------------------------------
module sha1sh_blkq (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  sha1sh_pkg::blk_t data_i,
  output logic             full_o,
  input  logic             pop_i,
  output sha1sh_pkg::blk_t data_o,
  output logic             empty_o
);
  import sha1sh_pkg::*;

  blk_t             mem_q [QDepth];
  logic [QPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCntW-1:0] cnt_q;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == QCntW'(QDepth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

### rtl/core/sha1sh_engine.sv
// ----------------------------------------------------------------------------
// sha1sh_engine
// SHA-1 compression, one round per cycle with a rolling schedule window.
// ----------------------------------------------------------------------------
module sha1sh_engine (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  sha1sh_pkg::blk_t blk_i,
  input  logic             blk_empty_i,
  output logic             blk_pop_o,
  output sha1sh_pkg::dig_t dig_o,
  input  logic             dig_free_i
);
  import sha1sh_pkg::*;

  typedef enum logic [2:0] {
    E_IDLE   = 3'b001,
    E_ROUND  = 3'b010,
    E_UPDATE = 3'b100
  } eng_state_e;

  eng_state_e                  state_q, state_d;
  logic [RoundW-1:0]           round_q;
  logic                        last_q;
  dig_words_t                  chain_q;
  logic [DigWords-1:0][WordW-1:0] vars_q;
  blk_words_t                  win_q;
  logic [WordW-1:0]            w_next, t;
  dig_words_t                  sum;
  logic                        update_go;

  // win_q holds w[r] .. w[r+15]; w[r+16] is formed every round
  assign w_next = rotl1(win_q[13] ^ win_q[8] ^ win_q[2] ^ win_q[0]);
  assign t = round_fk(round_q, vars_q[1], vars_q[2], vars_q[3])
           + rotl5(vars_q[0]) + vars_q[4] + win_q[0];

  always_comb begin
    for (int k = 0; k < DigWords; k++) begin
      sum[k] = chain_q[k] + vars_q[k];
    end
  end

  assign blk_pop_o   = (state_q == E_IDLE) && !blk_empty_i;
  assign update_go   = (state_q == E_UPDATE) && (!last_q || dig_free_i);
  assign dig_o.valid = update_go && last_q;
  assign dig_o.words = sum;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      E_IDLE:   if (blk_pop_o) state_d = E_ROUND;
      E_ROUND:  if (round_q == LastRound) state_d = E_UPDATE;
      E_UPDATE: if (update_go) state_d = E_IDLE;
      default:  state_d = E_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= E_IDLE;
      round_q <= '0;
      last_q  <= 1'b0;
      chain_q <= InitChain;
    end else begin
      state_q <= state_d;
      if (blk_pop_o) begin
        round_q <= '0;
        last_q  <= blk_i.last;
      end else if (state_q == E_ROUND) begin
        round_q <= round_q + 1'b1;
      end
      if (update_go) begin
        chain_q <= last_q ? InitChain : sum;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (blk_pop_o) begin
      win_q  <= blk_i.words;
      vars_q <= chain_q;
    end else if (state_q == E_ROUND) begin
      win_q     <= {w_next, win_q[BlkWords-1:1]};
      vars_q[4] <= vars_q[3];
      vars_q[3] <= vars_q[2];
      vars_q[2] <= rotl30(vars_q[1]);
      vars_q[1] <= vars_q[0];
      vars_q[0] <= t;
    end
  end

endmodule

### rtl/core/sha1sh_out.sv
// ----------------------------------------------------------------------------
// sha1sh_out
// Holds a finished digest and hands it out one word per transaction.
// ----------------------------------------------------------------------------
module sha1sh_out (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  sha1sh_pkg::dig_t           dig_i,
  output logic                       dig_free_o,
  output logic                       empty,
  input  logic                       pop,
  output logic [sha1sh_pkg::WordW-1:0] digest_word_o,
  output logic [sha1sh_pkg::IdxW-1:0]  word_index_o,
  output logic                       last_word_o
);
  import sha1sh_pkg::*;

  logic             valid_q;
  logic [IdxW-1:0]  idx_q;
  logic [WordW-1:0] words_q [DigWords];

  assign empty         = !valid_q;
  assign dig_free_o    = !valid_q;
  assign digest_word_o = words_q[idx_q];
  assign word_index_o  = idx_q;
  assign last_word_o   = (idx_q == LastIdx);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= '0;
    end else if (dig_i.valid) begin
      valid_q <= 1'b1;
      idx_q   <= '0;
    end else if (pop && valid_q) begin
      if (idx_q == LastIdx) begin
        valid_q <= 1'b0;
        idx_q   <= '0;
      end else begin
        idx_q <= idx_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (dig_i.valid) begin
      for (int k = 0; k < DigWords; k++) begin
        words_q[k] <= dig_i.words[k];
      end
    end
  end

endmodule

### rtl/core/sha1_stream_hasher_unit.sv
// ----------------------------------------------------------------------------
// sha1_stream_hasher_unit
// SHA-1 over a byte stream; five digest words per message.
// ----------------------------------------------------------------------------
// Throughput: one input transaction per cycle while the front packs a block;
// the front holds off input while it hands a full block or the one or two
// padding blocks to the queue. Sustained rate is set by the compression
// engine, which loads each block, runs 80 rounds and updates the chain.
// The first digest word is registered in the output stage when the engine
// finishes the chain update for the last padding block.
// Reset: control state clears, chain = IV.
module sha1_stream_hasher_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input queue side
  input  logic [7:0]  data_byte_i,
  input  logic        has_byte_i,
  input  logic        end_of_message_i,
  input  logic        push,
  output logic        full,
  // result queue side
  output logic [31:0] digest_word_o,
  output logic [2:0]  word_index_o,
  output logic        last_word_o,
  output logic        empty,
  input  logic        pop
);
  import sha1sh_pkg::*;

  // Front -> block queue
  blk_t fr_blk;
  logic fr_push;
  logic q_full;

  // Block queue -> engine
  blk_t q_blk;
  logic q_empty;
  logic eng_pop;

  // Engine -> output stage
  dig_t eng_dig;
  logic out_free;

  // Front: accepts a transaction per cycle while not full, packs bytes
  // big-endian, and turns the end of a message into one or two padding
  // blocks carrying the 0x80 marker and the 64-bit bit length.
  sha1sh_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .data_byte_i      (data_byte_i),
    .has_byte_i       (has_byte_i),
    .end_of_message_i (end_of_message_i),
    .push             (push),
    .full             (full),
    .blk_o            (fr_blk),
    .blk_push_o       (fr_push),
    .blk_full_i       (q_full)
  );

  // Two-entry block queue: the front keeps filling the next block while
  // the engine is still grinding on the previous one.
  sha1sh_blkq u_blkq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (fr_push),
    .data_i  (fr_blk),
    .full_o  (q_full),
    .pop_i   (eng_pop),
    .data_o  (q_blk),
    .empty_o (q_empty)
  );

  // Engine: one round per cycle; after the final block of a message it
  // publishes the digest and reloads the initial chaining value. It holds
  // in the update step while the previous digest is still being read.
  sha1sh_engine u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .blk_i       (q_blk),
    .blk_empty_i (q_empty),
    .blk_pop_o   (eng_pop),
    .dig_o       (eng_dig),
    .dig_free_i  (out_free)
  );

  // Output stage: digest words h0..h4, one per pop transaction.
  sha1sh_out u_out (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .dig_i         (eng_dig),
    .dig_free_o    (out_free),
    .empty         (empty),
    .pop           (pop),
    .digest_word_o (digest_word_o),
    .word_index_o  (word_index_o),
    .last_word_o   (last_word_o)
  );

endmodule

### bench/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for sha1_stream_hasher_unit. Byte streams are pushed
// through the input queue side. A built-in SHA-1 predictor builds the five
// digest words of each message. Every popped word is compared against them.
// ----------------------------------------------------------------------------
module tb;

  localparam int unsigned QuietLimit  = 4000; // cycles with no transaction
  localparam int unsigned DrainCycles = 200;  // settle time after last word
  localparam int unsigned RandItems   = 450;
  localparam int unsigned NumPhases   = 4;

  // --------------------------------------------------------------------------
  // Digest predictor and scoreboard
  // --------------------------------------------------------------------------
  class digest_scoreboard;
    typedef struct {
      bit [31:0] word;
      bit [2:0]  idx;
      bit        last;
    } digest_word_t;

    localparam bit [7:0] PadByte   = 8'h80;
    localparam int       LenOffset = 56;
    localparam bit [31:0] RoundK [4] = '{32'h5A827999, 32'h6ED9EBA1,
                                         32'h8F1BBCDC, 32'hCA62C1D6};
    localparam bit [31:0] ChainIv [5] = '{32'h67452301, 32'hEFCDAB89,
                                          32'h98BADCFE, 32'h10325476,
                                          32'hC3D2E1F0};

    bit [31:0]    chain [5];
    bit [31:0]    sched [16];
    int unsigned  fill;
    bit [60:0]    nbytes;
    digest_word_t expected_words [$];
    int unsigned  errors;

    function new();
      restart();
      errors = 0;
    endfunction

    function void restart();
      chain  = ChainIv;
      fill   = 0;
      nbytes = '0;
    endfunction

    // Pack one byte big-endian; a full block runs the 80-round compression.
    function void absorb(bit [7:0] b);
      bit [31:0] w [16];
      bit [31:0] a, bb, c, d, e, f, t;
      int        r, s;
      if (fill % 4 == 0) sched[fill / 4] = '0;
      sched[fill / 4][31 - 8 * (fill % 4) -: 8] = b;
      fill++;
      if (fill == 64) begin
        w  = sched;
        a  = chain[0];
        bb = chain[1];
        c  = chain[2];
        d  = chain[3];
        e  = chain[4];
        for (r = 0; r < 80; r++) begin
          s = r % 16;
          if (r >= 16) begin
            t    = w[(s + 13) % 16] ^ w[(s + 8) % 16] ^ w[(s + 2) % 16] ^ w[s];
            w[s] = {t[30:0], t[31]};
          end
          if (r < 20)      f = ((bb & c) | (~bb & d)) + RoundK[0];
          else if (r < 40) f = (bb ^ c ^ d) + RoundK[1];
          else if (r < 60) f = ((bb & c) | (bb & d) | (c & d)) + RoundK[2];
          else             f = (bb ^ c ^ d) + RoundK[3];
          t  = f + {a[26:0], a[31:27]} + e + w[s];
          e  = d;
          d  = c;
          c  = {bb[1:0], bb[31:2]};
          bb = a;
          a  = t;
        end
        chain[0] += a;
        chain[1] += bb;
        chain[2] += c;
        chain[3] += d;
        chain[4] += e;
        fill = 0;
      end
    endfunction

    // Accepted input transaction; on end of message, pad and queue the digest.
    function void note_transaction(bit [7:0] b, bit has, bit eom);
      bit [63:0] bit_len;
      int        k;
      if (has) begin
        absorb(b);
        nbytes = nbytes + 61'd1;
      end
      if (!eom) return;
      bit_len = {nbytes, 3'b000};
      absorb(PadByte);
      while (fill != LenOffset) absorb(8'h00);
      for (k = 0; k < 8; k++) absorb(bit_len[63 - 8 * k -: 8]);
      for (k = 0; k < 5; k++)
        expected_words.push_back('{word: chain[k], idx: 3'(k), last: (k == 4)});
      restart();
    endfunction

    // Popped result transaction against the oldest expected digest word.
    function void check_result(logic [31:0] word, logic [2:0] idx, logic last);
      digest_word_t exp_w;
      if (expected_words.size() == 0) begin
        $error("unexpected digest word %h, index %0d", word, idx);
        errors++;
        return;
      end
      exp_w = expected_words.pop_front();
      if (word !== exp_w.word) begin
        $error("digest_word: expected %h, got %h", exp_w.word, word);
        errors++;
      end
      if (idx !== exp_w.idx) begin
        $error("word_index: expected %0d, got %0d", exp_w.idx, idx);
        errors++;
      end
      if (last !== exp_w.last) begin
        $error("last_word: expected %0b, got %0b", exp_w.last, last);
        errors++;
      end
    endfunction

    function int unsigned outstanding();
      return expected_words.size();
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset, DUT
  // --------------------------------------------------------------------------
  logic        clk_i            = 1'b0;
  logic        rst_ni           = 1'b0;
  logic [7:0]  data_byte_i      = 8'h00;
  logic        has_byte_i       = 1'b0;
  logic        end_of_message_i = 1'b0;
  logic        push             = 1'b0;
  logic        full;
  logic [31:0] digest_word_o;
  logic [2:0]  word_index_o;
  logic        last_word_o;
  logic        empty;
  logic        pop              = 1'b0;

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  sha1_stream_hasher_unit dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .data_byte_i      (data_byte_i),
    .has_byte_i       (has_byte_i),
    .end_of_message_i (end_of_message_i),
    .push             (push),
    .full             (full),
    .digest_word_o    (digest_word_o),
    .word_index_o     (word_index_o),
    .last_word_o      (last_word_o),
    .empty            (empty),
    .pop              (pop)
  );

  digest_scoreboard sb = new();

  // Idle rates in percent, changed per phase
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned msg_items      = 0; // random items sent, noise included
  int unsigned quiet_cycles   = 0;

  // Result side: pop is redrawn every cycle from the current stall rate.
  always @(posedge clk_i) begin
    pop <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Monitor: all handshake signals are sampled at the edge, before any NBA
  // update, so acceptance is seen exactly as the DUT sees it.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (pop && !empty) sb.check_result(digest_word_o, word_index_o, last_word_o);
      if (push && !full) sb.note_transaction(data_byte_i, has_byte_i, end_of_message_i);
      if ((pop && !empty) || (push && !full)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Watchdog: nothing moved on either side for far too long
  always @(posedge clk_i) begin
    if (quiet_cycles >= QuietLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  // Drives one item and returns once the DUT has accepted it.
  // Only one NBA to push per time step: idle lowers it, a new item raises it.
  task automatic send_item(input logic [7:0] b, input logic has, input logic eom);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push             <= 1'b1;
    data_byte_i      <= b;
    has_byte_i       <= has;
    end_of_message_i <= eom;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
  endtask

  // One message with random content. Length mix: short most often, many around
  // the 55/56/64 byte padding boundaries, some spanning two or three blocks.
  // Length is clipped to the items left in the phase budget.
  // The end flag rides on the last byte or on a separate byte-less item.
  task automatic send_random_message(input int unsigned budget);
    int unsigned len;
    int unsigned pick;
    bit          end_on_byte;
    int unsigned i;
    pick = $urandom_range(99);
    if (pick < 45)      len = $urandom_range(6);
    else if (pick < 75) len = $urandom_range(66, 52);
    else                len = $urandom_range(130);
    if (len > budget) len = budget;
    end_on_byte = (len != 0) && ($urandom_range(1) == 1);
    for (i = 0; i < len; i++) begin
      // noise: item with neither byte nor end, must be ignored
      if ($urandom_range(7) == 0) begin
        send_item(8'($urandom_range(255)), 1'b0, 1'b0);
        msg_items++;
      end
      send_item(8'($urandom_range(255)), 1'b1, end_on_byte && (i == len - 1));
      msg_items++;
    end
    if (!end_on_byte) begin
      send_item(8'($urandom_range(255)), 1'b0, 1'b1);
      msg_items++;
    end
  endtask

  initial begin
    int unsigned p;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part, no idling
    send_item(8'hA5, 1'b0, 1'b0);   // ignored item before anything
    send_item(8'h00, 1'b0, 1'b1);   // empty message
    send_item(8'h61, 1'b1, 1'b0);   // "abc", end on the last byte
    send_item(8'h62, 1'b1, 1'b0);
    send_item(8'h63, 1'b1, 1'b1);
    send_item(8'h61, 1'b1, 1'b0);   // "abc" again, end on its own item
    send_item(8'h62, 1'b1, 1'b0);
    send_item(8'hFF, 1'b0, 1'b0);   // ignored mid-message, data must not leak
    send_item(8'h63, 1'b1, 1'b0);
    send_item(8'hFF, 1'b0, 1'b1);
    send_item(8'hFF, 1'b1, 1'b1);   // single all-ones byte with end
    send_item(8'h00, 1'b1, 1'b0);   // single zero byte, then end
    send_item(8'hFF, 1'b0, 1'b1);

    // Random part in four idle phases: none, sender, receiver, both
    for (p = 0; p < NumPhases; p++) begin
      case (p)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 78; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 78; end
        default: begin send_idle_pct = 22; recv_stall_pct = 22; end
      endcase
      while (msg_items < RandItems * (p + 1) / NumPhases)
        send_random_message(RandItems * (p + 1) / NumPhases - msg_items);
    end

    push <= 1'b0;
    @(posedge clk_i);
    while (sb.outstanding() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (sb.errors == 0 && sb.outstanding() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
